// ----- design/ctct_pkg.sv -----
// Shared types, constants and helper functions for the color centroid tracker.
package ctct_pkg;

    localparam int CFG_INDEX_BITS   = 3;
    localparam int CFG_DATA_BITS    = 16;
    localparam int NUM_LANES        = 2;
    localparam int ACC_BITS         = 24;
    localparam int DIST_IN_BITS     = 26;
    localparam int DIST_BITS        = 13;
    localparam int INV_BITS         = 24;
    localparam int SUM_BITS         = 64;
    localparam int WEIGHT_BITS      = 48;
    localparam int FIELD_BITS       = 12;
    localparam int CLAMP_BITS       = 15;
    localparam int INV_SHIFT        = 12;
    localparam int RESET_MAX_Q4     = 7066;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_RED   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_GREEN = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_BLUE  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH        = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT       = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MARGIN       = 3'd6;

    localparam logic signed [ACC_BITS-1:0] CY_Q10  = 24'sd1192;
    localparam logic signed [ACC_BITS-1:0] CVR_Q10 = 24'sd1634;
    localparam logic signed [ACC_BITS-1:0] CVG_Q10 = 24'sd833;
    localparam logic signed [ACC_BITS-1:0] CUG_Q10 = 24'sd400;
    localparam logic signed [ACC_BITS-1:0] CUB_Q10 = 24'sd2066;
    localparam logic signed [ACC_BITS-1:0] LUMA_OFFSET   = 24'sd16;
    localparam logic signed [ACC_BITS-1:0] CHROMA_OFFSET = 24'sd128;
    localparam logic signed [ACC_BITS-1:0] CHANNEL_TOP   = 24'sd255;
    localparam logic [7:0] CHANNEL_MID = 8'd128;
    localparam logic [7:0] CHANNEL_FULL = 8'd255;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       frame_end;
    } pixel_pair_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] centroid_x;
        logic [FIELD_BITS-1:0] centroid_y;
        logic                  target_found;
        logic                  move_right;
        logic                  move_left;
        logic                  move_up;
        logic                  move_down;
        logic                  hold_still;
    } track_result_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef enum logic [3:0] {
        LN_IDLE,
        LN_CONV,
        LN_SQUARE,
        LN_ROOT_GO,
        LN_ROOT_WAIT,
        LN_FRAC,
        LN_SCORE,
        LN_PRODUCT,
        LN_DONE
    } lane_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LANES,
        ST_XSTART,
        ST_XWAIT,
        ST_YSTART,
        ST_YWAIT,
        ST_ISTART,
        ST_IWAIT,
        ST_FLAGS
    } ctl_state_t;

    function automatic logic [7:0] to_channel(input logic signed [ACC_BITS-1:0] acc);
        logic signed [ACC_BITS-1:0] v;
        v = acc >>> 10;
        if (acc < 0) begin
            return 8'd0;
        end else if (v > CHANNEL_TOP) begin
            return CHANNEL_FULL;
        end
        return v[7:0];
    endfunction

    function automatic logic [7:0] channel_max(input logic [7:0] c);
        return (c > CHANNEL_MID) ? c : CHANNEL_FULL - c;
    endfunction

endpackage

// ----- design/color_target_centroid_tracker.sv -----
// Top level of the color target centroid tracker.
//
// Usage: s_* carries one YUYV pair per item (two pixels) in raster order;
// frame_end marks the last pair of a frame. Items without frame_end give no
// result; a frame_end item gives one result on m_* once the frame is closed.
// cfg_* writes registers 0..6 (target RGB, threshold, width, height, margin);
// it is always ready; the user must write it only while no frame work is
// pending, which the block does not enforce. A new pair is taken only once
// both lanes finish the last; the two pixels run side by side, each lane
// bound by its 13-step serial square root. Frame end: three 64-step serial
// divisions (centroid x, centroid y, inverse of the new maximum distance).
// The output register holds the result; the next items are accepted while it
// waits, and only the next frame end stalls until m_ready takes it.
// Reset: synchronous, active low; registers take their reset values, sums and
// counters clear and the inverse distance loads its reset-target value.
module color_target_centroid_tracker
    import ctct_pkg::*;
#(
    parameter int COORD_BITS      = 12,
    parameter int SCORE_FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  pixel_pair_t               s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output track_result_t             m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);
    localparam int CB  = COORD_BITS;
    localparam int SFB = SCORE_FRAC_BITS;
    localparam int WB  = CB + SFB + 2;
    localparam logic [INV_BITS-1:0] INV_RESET =
        INV_BITS'((64'(1) << (SFB + INV_SHIFT)) / RESET_MAX_Q4);
    localparam logic [SUM_BITS-1:0] INV_DIVIDEND = SUM_BITS'(1) << (SFB + INV_SHIFT);
    localparam logic [CLAMP_BITS-1:0] WIDTH_MAX = CLAMP_BITS'(1) << CB;
    localparam logic [CLAMP_BITS-1:0] WIDTH_MIN = CLAMP_BITS'(2);

    ctl_state_t state_reg, state_next;

    rgb_t           target_reg;
    logic [15:0]    thr_cfg_reg;
    logic [12:0]    fw_reg, fh_reg;
    logic [11:0]    margin_reg;
    logic [CB-1:0]  col_reg, row_reg;
    logic [SUM_BITS-1:0]    xsum_reg, ysum_reg;
    logic [WEIGHT_BITS-1:0] wsum_reg;
    logic [INV_BITS-1:0]    inv_reg;
    logic                   frame_end_reg;
    logic [SUM_BITS-1:0]    cx_reg, cy_reg;
    logic                   m_valid_reg;
    track_result_t          m_data_reg;

    logic s_accept;
    logic lanes_finish;
    logic out_load;
    logic div_start;
    logic root_start;
    logic [SUM_BITS-1:0]    div_dividend;
    logic [WEIGHT_BITS-1:0] div_divisor;
    logic                   div_done;
    logic [SUM_BITS-1:0]    div_quot;
    logic                   max_done;
    logic [DIST_BITS-1:0]   max_root;
    logic [DIST_BITS-1:0]   max_q4;

    logic [SFB+15:0]        thr_full;
    logic [SFB-1:0]         thr;
    logic [CLAMP_BITS-1:0]  fw_even, fw_clamp;
    logic [CB:0]            effw;
    logic [CB:0]            col_sum;
    logic [15:0]            mr_sq, mg_sq, mb_sq;
    logic [17:0]            max_sum;

    logic [7:0]    lane_luma [NUM_LANES];
    logic [CB-1:0] lane_x    [NUM_LANES];
    logic          lane_done [NUM_LANES];
    logic          lane_match[NUM_LANES];
    logic [SFB+1:0] lane_w   [NUM_LANES];
    logic [WB-1:0] lane_xw   [NUM_LANES];
    logic [WB-1:0] lane_yw   [NUM_LANES];

    logic [SUM_BITS-1:0]    xadd0, xadd1, yadd0, yadd1;
    logic [WEIGHT_BITS-1:0] wadd0, wadd1;

    logic                found;
    logic [SUM_BITS-1:0] cxc, cyc, mg64, cx_m, cy_m;
    logic                right, left, up, down;
    track_result_t       result;

    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        thr_full = {thr_cfg_reg, {SFB{1'b0}}} >> 16;
        thr      = thr_full[SFB-1:0];
        fw_even  = {2'b00, fw_reg[12:1], 1'b0};
        if (fw_even < WIDTH_MIN) begin
            fw_clamp = WIDTH_MIN;
        end else if (fw_even > WIDTH_MAX) begin
            fw_clamp = WIDTH_MAX;
        end else begin
            fw_clamp = fw_even;
        end
        effw    = fw_clamp[CB:0];
        col_sum = {1'b0, col_reg} + (CB+1)'(2);
        mr_sq   = 16'(channel_max(target_reg.red))   * 16'(channel_max(target_reg.red));
        mg_sq   = 16'(channel_max(target_reg.green)) * 16'(channel_max(target_reg.green));
        mb_sq   = 16'(channel_max(target_reg.blue))  * 16'(channel_max(target_reg.blue));
        max_sum = {2'b00, mr_sq} + {2'b00, mg_sq} + {2'b00, mb_sq};
        max_q4  = (max_root == '0) ? DIST_BITS'(1) : max_root;
    end

    assign lane_luma[0] = s_data.luma_first;
    assign lane_luma[1] = s_data.luma_second;
    assign lane_x[0]    = col_reg;
    assign lane_x[1]    = col_reg + CB'(1);

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        ctct_lane #(
            .COORD_BITS      (CB),
            .SCORE_FRAC_BITS (SFB)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .start       (s_accept),
            .luma        (lane_luma[i]),
            .chroma_blue (s_data.chroma_blue),
            .chroma_red  (s_data.chroma_red),
            .x_pos       (lane_x[i]),
            .y_pos       (row_reg),
            .target      (target_reg),
            .threshold   (thr),
            .inverse     (inv_reg),
            .done        (lane_done[i]),
            .matched     (lane_match[i]),
            .weight      (lane_w[i]),
            .x_weight    (lane_xw[i]),
            .y_weight    (lane_yw[i])
        );
    end

    always_comb begin
        xadd0 = lane_match[0] ? SUM_BITS'(lane_xw[0]) : '0;
        xadd1 = lane_match[1] ? SUM_BITS'(lane_xw[1]) : '0;
        yadd0 = lane_match[0] ? SUM_BITS'(lane_yw[0]) : '0;
        yadd1 = lane_match[1] ? SUM_BITS'(lane_yw[1]) : '0;
        wadd0 = lane_match[0] ? WEIGHT_BITS'(lane_w[0]) : '0;
        wadd1 = lane_match[1] ? WEIGHT_BITS'(lane_w[1]) : '0;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_LANES;
            ST_LANES:  if (lane_done[0]) state_next = frame_end_reg ? ST_XSTART : ST_IDLE;
            ST_XSTART: state_next = ST_XWAIT;
            ST_XWAIT:  if (div_done) state_next = ST_YSTART;
            ST_YSTART: state_next = ST_YWAIT;
            ST_YWAIT:  if (div_done) state_next = ST_ISTART;
            ST_ISTART: state_next = ST_IWAIT;
            ST_IWAIT:  if (div_done) state_next = ST_FLAGS;
            ST_FLAGS:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        lanes_finish = (state_reg == ST_LANES) && lane_done[0];
        out_load     = (state_reg == ST_FLAGS) && (!m_valid_reg || m_ready);
        root_start   = (state_reg == ST_XSTART);
        div_start    = (state_reg == ST_XSTART) || (state_reg == ST_YSTART) ||
                       (state_reg == ST_ISTART);
        unique case (state_reg)
            ST_YSTART: begin
                div_dividend = ysum_reg;
                div_divisor  = wsum_reg;
            end
            ST_ISTART: begin
                div_dividend = INV_DIVIDEND;
                div_divisor  = WEIGHT_BITS'(max_q4);
            end
            default: begin
                div_dividend = xsum_reg;
                div_divisor  = wsum_reg;
            end
        endcase
    end

    always_comb begin
        found = (wsum_reg != '0);
        cxc   = SUM_BITS'(effw[CB:1]);
        cyc   = SUM_BITS'(fh_reg[12:1]);
        mg64  = SUM_BITS'(margin_reg);
        cx_m  = cx_reg + mg64;
        cy_m  = cy_reg + mg64;
        right = found && (cx_reg > cxc + mg64);
        left  = found && (cx_m < cxc);
        up    = found && (cy_m < cyc);
        down  = found && (cy_reg > cyc + mg64);
        result.centroid_x   = found ? cx_reg[FIELD_BITS-1:0] : '0;
        result.centroid_y   = found ? cy_reg[FIELD_BITS-1:0] : '0;
        result.target_found = found;
        result.move_right   = right;
        result.move_left    = left;
        result.move_up      = up;
        result.move_down    = down;
        result.hold_still   = !(right || left || up || down);
    end

    ctct_divider #(
        .N_BITS (SUM_BITS),
        .D_BITS (WEIGHT_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    ctct_isqrt #(
        .IN_BITS (DIST_IN_BITS)
    ) u_max_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .value   ({max_sum, 8'h00}),
        .done    (max_done),
        .root    (max_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            target_reg    <= '{red: CHANNEL_FULL, green: 8'd0, blue: 8'd0};
            thr_cfg_reg   <= 16'd52429;
            fw_reg        <= 13'd640;
            fh_reg        <= 13'd480;
            margin_reg    <= 12'd30;
            col_reg       <= '0;
            row_reg       <= '0;
            xsum_reg      <= '0;
            ysum_reg      <= '0;
            wsum_reg      <= '0;
            inv_reg       <= INV_RESET;
            frame_end_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_TARGET_RED:   target_reg.red   <= cfg_data[7:0];
                    CFG_TARGET_GREEN: target_reg.green <= cfg_data[7:0];
                    CFG_TARGET_BLUE:  target_reg.blue  <= cfg_data[7:0];
                    CFG_THRESHOLD:    thr_cfg_reg      <= cfg_data;
                    CFG_WIDTH:        fw_reg           <= cfg_data[12:0];
                    CFG_HEIGHT:       fh_reg           <= cfg_data[12:0];
                    CFG_MARGIN:       margin_reg       <= cfg_data[11:0];
                    default: ;
                endcase
            end
            if (s_accept) begin
                frame_end_reg <= s_data.frame_end;
                if (s_data.frame_end) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end else if (col_sum >= effw) begin
                    col_reg <= '0;
                    if (row_reg != {CB{1'b1}}) begin
                        row_reg <= row_reg + CB'(1);
                    end
                end else begin
                    col_reg <= col_sum[CB-1:0];
                end
            end
            if (lanes_finish) begin
                xsum_reg <= xsum_reg + xadd0 + xadd1;
                ysum_reg <= ysum_reg + yadd0 + yadd1;
                wsum_reg <= wsum_reg + wadd0 + wadd1;
            end else if (out_load) begin
                xsum_reg <= '0;
                ysum_reg <= '0;
                wsum_reg <= '0;
            end
            if (state_reg == ST_IWAIT && div_done) begin
                inv_reg <= div_quot[INV_BITS-1:0];
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_XWAIT && div_done) begin
            cx_reg <= div_quot;
        end
        if (state_reg == ST_YWAIT && div_done) begin
            cy_reg <= div_quot;
        end
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a pair is still in the lanes");

    a_lanes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_done[0] == lane_done[1])
        else $error("pixel lanes finished out of step");

    a_max_root_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        max_done |-> state_reg == ST_XWAIT)
        else $error("maximum distance root finished outside the first division");

    a_flags_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.move_left && m_data.move_right) &&
                    !(m_data.move_up && m_data.move_down) &&
                    (m_data.target_found || m_data.hold_still))
        else $error("contradictory move flags in result");
`endif

endmodule

// ----- design/ctct_isqrt.sv -----
// Iterative integer square root, one result bit per cycle.
module ctct_isqrt #(
    parameter int IN_BITS = 26
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [IN_BITS-1:0]     value,
    output logic                   done,
    output logic [IN_BITS/2-1:0]   root
);
    localparam int OUT_BITS = IN_BITS / 2;
    localparam int CNT_BITS = $clog2(OUT_BITS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [IN_BITS-1:0]    val_reg, val_next;
    logic [OUT_BITS+1:0]   rem_reg, rem_next;
    logic [OUT_BITS-1:0]   root_reg, root_next;
    logic [OUT_BITS+1:0]   rem_sh;
    logic [OUT_BITS+1:0]   trial;

    always_comb begin
        rem_sh    = {rem_reg[OUT_BITS-1:0], val_reg[IN_BITS-1:IN_BITS-2]};
        trial     = {root_reg, 2'b01};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            val_next = {val_reg[IN_BITS-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[OUT_BITS-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[OUT_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(OUT_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- design/ctct_divider.sv -----
// Restoring serial divider, one quotient bit per cycle.
module ctct_divider #(
    parameter int N_BITS = 64,
    parameter int D_BITS = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [N_BITS-1:0] dividend,
    input  logic [D_BITS-1:0] divisor,
    output logic              done,
    output logic [N_BITS-1:0] quotient
);
    localparam int CNT_BITS = $clog2(N_BITS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [N_BITS-1:0]   work_reg, work_next;
    logic [D_BITS-1:0]   rem_reg, rem_next;
    logic [D_BITS-1:0]   div_reg, div_next;
    logic [D_BITS:0]     rem_sh;
    logic [D_BITS:0]     rem_sub;

    always_comb begin
        rem_sh    = {rem_reg, work_reg[N_BITS-1]};
        rem_sub   = rem_sh - {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, div_reg}) begin
                rem_next  = rem_sub[D_BITS-1:0];
                work_next = {work_reg[N_BITS-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[D_BITS-1:0];
                work_next = {work_reg[N_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(N_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

// ----- design/ctct_lane.sv -----
// One pixel lane: color conversion, distance, score and weighted products.
module ctct_lane
    import ctct_pkg::*;
#(
    parameter int COORD_BITS      = 12,
    parameter int SCORE_FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [7:0]                            luma,
    input  logic [7:0]                            chroma_blue,
    input  logic [7:0]                            chroma_red,
    input  logic [COORD_BITS-1:0]                 x_pos,
    input  logic [COORD_BITS-1:0]                 y_pos,
    input  rgb_t                                  target,
    input  logic [SCORE_FRAC_BITS-1:0]            threshold,
    input  logic [INV_BITS-1:0]                   inverse,
    output logic                                  done,
    output logic                                  matched,
    output logic [SCORE_FRAC_BITS+1:0]            weight,
    output logic [COORD_BITS+SCORE_FRAC_BITS+1:0] x_weight,
    output logic [COORD_BITS+SCORE_FRAC_BITS+1:0] y_weight
);
    localparam int SFB       = SCORE_FRAC_BITS;
    localparam int PROD_BITS = DIST_BITS + INV_BITS;
    localparam int FRAC_BITS = PROD_BITS - INV_SHIFT;
    localparam int XW_BITS   = COORD_BITS + SFB + 2;
    localparam logic [FRAC_BITS-1:0] SCORE_ONE = FRAC_BITS'(1) << SFB;

    lane_state_t state_reg, state_next;
    logic        root_start;
    logic        root_done;
    logic [DIST_BITS-1:0] root_val;

    logic [7:0]            luma_reg, cb_reg, cr_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    rgb_t                  rgb_reg;
    logic [15:0]           sq_r_reg, sq_g_reg, sq_b_reg;
    logic [PROD_BITS-1:0]  frac_prod_reg;
    logic                  match_reg;
    logic [SFB+1:0]        w_reg;
    logic [COORD_BITS+SFB+1:0] xw_reg, yw_reg;

    logic signed [ACC_BITS-1:0] yy, uu, vv;
    logic signed [ACC_BITS-1:0] acc_r, acc_g, acc_b;
    logic signed [9:0]  dr, dg, db;
    logic signed [19:0] sqf_r, sqf_g, sqf_b;
    logic [17:0]        d2;
    logic [FRAC_BITS-1:0] frac, frac_sat;
    logic [SFB:0]       score;
    logic [SFB+1:0]     w_full;

    always_comb begin
        yy    = $signed({{(ACC_BITS-8){1'b0}}, luma_reg}) - LUMA_OFFSET;
        uu    = $signed({{(ACC_BITS-8){1'b0}}, cb_reg}) - CHROMA_OFFSET;
        vv    = $signed({{(ACC_BITS-8){1'b0}}, cr_reg}) - CHROMA_OFFSET;
        acc_r = CY_Q10 * yy + CVR_Q10 * vv;
        acc_g = CY_Q10 * yy - CVG_Q10 * vv - CUG_Q10 * uu;
        acc_b = CY_Q10 * yy + CUB_Q10 * uu;
        dr    = $signed({2'b00, rgb_reg.red})   - $signed({2'b00, target.red});
        dg    = $signed({2'b00, rgb_reg.green}) - $signed({2'b00, target.green});
        db    = $signed({2'b00, rgb_reg.blue})  - $signed({2'b00, target.blue});
        sqf_r = 20'(dr) * 20'(dr);
        sqf_g = 20'(dg) * 20'(dg);
        sqf_b = 20'(db) * 20'(db);
        d2    = {2'b00, sq_r_reg} + {2'b00, sq_g_reg} + {2'b00, sq_b_reg};
        frac  = frac_prod_reg[PROD_BITS-1:INV_SHIFT];
        frac_sat = (frac > SCORE_ONE) ? SCORE_ONE : frac;
        score = (SFB+1)'(SCORE_ONE - frac_sat);
        w_full = {1'b0, score} + {1'b0, SCORE_ONE[SFB:0]} - {2'b00, threshold};
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            LN_IDLE:      if (start) state_next = LN_CONV;
            LN_CONV:      state_next = LN_SQUARE;
            LN_SQUARE:    state_next = LN_ROOT_GO;
            LN_ROOT_GO:   state_next = LN_ROOT_WAIT;
            LN_ROOT_WAIT: if (root_done) state_next = LN_FRAC;
            LN_FRAC:      state_next = LN_SCORE;
            LN_SCORE:     state_next = LN_PRODUCT;
            LN_PRODUCT:   state_next = LN_DONE;
            LN_DONE:      state_next = LN_IDLE;
            default:      state_next = LN_IDLE;
        endcase
    end

    always_comb begin
        root_start = (state_reg == LN_ROOT_GO);
        done       = (state_reg == LN_DONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LN_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == LN_IDLE && start) begin
            luma_reg <= luma;
            cb_reg   <= chroma_blue;
            cr_reg   <= chroma_red;
            x_reg    <= x_pos;
            y_reg    <= y_pos;
        end
        if (state_reg == LN_CONV) begin
            rgb_reg <= '{red: to_channel(acc_r), green: to_channel(acc_g),
                         blue: to_channel(acc_b)};
        end
        if (state_reg == LN_SQUARE) begin
            sq_r_reg <= sqf_r[15:0];
            sq_g_reg <= sqf_g[15:0];
            sq_b_reg <= sqf_b[15:0];
        end
        if (state_reg == LN_FRAC) begin
            frac_prod_reg <= PROD_BITS'(root_val) * PROD_BITS'(inverse);
        end
        if (state_reg == LN_SCORE) begin
            match_reg <= (score >= {1'b0, threshold});
            w_reg     <= w_full;
        end
        if (state_reg == LN_PRODUCT) begin
            xw_reg <= XW_BITS'(x_reg) * XW_BITS'(w_reg);
            yw_reg <= XW_BITS'(y_reg) * XW_BITS'(w_reg);
        end
    end

    ctct_isqrt #(
        .IN_BITS (DIST_IN_BITS)
    ) u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .value   ({d2, 8'h00}),
        .done    (root_done),
        .root    (root_val)
    );

    assign matched  = match_reg;
    assign weight   = w_reg;
    assign x_weight = xw_reg;
    assign y_weight = yw_reg;

endmodule

// ----- test/tb_color_target_centroid_tracker.sv -----
// Self-checking testbench for the color target centroid tracker: predicts each frame result.
module tb_color_target_centroid_tracker;
    import ctct_pkg::*;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  SETTLE_CYCLES  = 300;
    localparam int  RANDOM_ITEMS   = 1150;
    localparam int  ROW_LIMIT      = 4095;
    localparam int  X_LIMIT        = 4096;
    localparam longint unsigned SCORE_ONE   = 64'd65536;
    localparam longint unsigned WEIGHT_MASK = (64'd1 << 48) - 1;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    pixel_pair_t               s_data = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    track_result_t             m_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    color_target_centroid_tracker dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // tracker model state
    logic [7:0]      tgt_red = 8'd255, tgt_green = 8'd0, tgt_blue = 8'd0;
    logic [15:0]     thresh = 16'd52429;
    logic [12:0]     width_reg = 13'd640, height_reg = 13'd480;
    logic [11:0]     margin_reg = 12'd30;
    int unsigned     col_pos = 0, row_pos = 0;
    longint unsigned x_moment = 0, y_moment = 0, weight_sum = 0, inv_span = 0;

    track_result_t   expected_tracks[$];
    int              mismatches = 0, tracks_seen = 0, items_sent = 0, frames_closed = 0;
    bit              tx_steady = 1'b0, rx_steady = 1'b0;
    int              rx_hold_req = 0, rx_hold_left = 0, rx_stall = 0, idle_cycles = 0;

    function automatic int unsigned root32(input int unsigned v);
        int unsigned res, bit_w;
        res = 0;
        bit_w = 32'h4000_0000;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic int clamp_channel(input int acc);
        int v;
        if (acc < 0) return 0;
        v = acc >>> 10;
        return (v > 255) ? 255 : v;
    endfunction

    function automatic int unsigned channel_span(input logic [7:0] c);
        return (c > 8'd128) ? 32'(c) : 255 - 32'(c);
    endfunction

    function automatic int unsigned active_width();
        int unsigned w;
        w = 32'(width_reg & 13'h1FFE);
        if (w < 2) w = 2;
        if (w > X_LIMIT) w = X_LIMIT;
        return w;
    endfunction

    task automatic relatch_span();
        int unsigned sr, sg, sb, maxq4;
        sr = channel_span(tgt_red);
        sg = channel_span(tgt_green);
        sb = channel_span(tgt_blue);
        maxq4 = root32((sr * sr + sg * sg + sb * sb) << 8);
        if (maxq4 == 0) maxq4 = 1;
        inv_span = ((64'd1 << 28) / maxq4) & 64'hFF_FFFF;
    endtask

    task automatic weigh_pixel(input int luma, input int cb, input int cr, input int unsigned x);
        int yy, uu, vv, r, g, b, dr, dg, db;
        longint unsigned dq4, frac, score, w;
        yy = luma - 16;
        uu = cb - 128;
        vv = cr - 128;
        r = clamp_channel(int'(CY_Q10) * yy + int'(CVR_Q10) * vv);
        g = clamp_channel(int'(CY_Q10) * yy - int'(CVG_Q10) * vv - int'(CUG_Q10) * uu);
        b = clamp_channel(int'(CY_Q10) * yy + int'(CUB_Q10) * uu);
        dr = r - int'(tgt_red);
        dg = g - int'(tgt_green);
        db = b - int'(tgt_blue);
        dq4 = 64'(root32(int'(dr * dr + dg * dg + db * db) << 8));
        frac = (dq4 * inv_span) >> 12;
        if (frac > SCORE_ONE) frac = SCORE_ONE;
        score = SCORE_ONE - frac;
        if (score < 64'(thresh)) return;
        w = score + SCORE_ONE - 64'(thresh);
        x_moment += longint'(x) * w;
        y_moment += longint'(row_pos) * w;
        weight_sum = (weight_sum + w) & WEIGHT_MASK;
    endtask

    task automatic track_pair(input pixel_pair_t p);
        int unsigned effw;
        longint unsigned cx, cy, cxc, cyc, mg;
        track_result_t t;
        effw = active_width();
        weigh_pixel(int'(p.luma_first), int'(p.chroma_blue), int'(p.chroma_red), col_pos);
        weigh_pixel(int'(p.luma_second), int'(p.chroma_blue), int'(p.chroma_red),
                    col_pos + 1);
        col_pos += 2;
        if (col_pos >= effw) begin
            col_pos = 0;
            if (row_pos < ROW_LIMIT) row_pos++;
        end
        if (!p.frame_end) return;
        t = '0;
        t.target_found = (weight_sum != 0);
        if (t.target_found) begin
            cx = x_moment / weight_sum;
            cy = y_moment / weight_sum;
            cxc = 64'(effw) / 2;
            cyc = 64'(height_reg) / 2;
            mg = 64'(margin_reg);
            t.centroid_x = cx[11:0];
            t.centroid_y = cy[11:0];
            t.move_right = cx > cxc + mg;
            t.move_left  = cx + mg < cxc;
            t.move_up    = cy + mg < cyc;
            t.move_down  = cy > cyc + mg;
        end
        t.hold_still = !(t.move_right || t.move_left || t.move_up || t.move_down);
        expected_tracks.push_back(t);
        frames_closed++;
        col_pos = 0;
        row_pos = 0;
        x_moment = 0;
        y_moment = 0;
        weight_sum = 0;
        relatch_span();
    endtask

    function automatic int pick_gap(input bit allow_zero);
        int r;
        r = $urandom_range(0, 99);
        if (allow_zero && r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [7:0] sat8(input int v);
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // pixel pair tinted toward the target color or fully random
    function automatic pixel_pair_t tinted_pair(input bit last);
        pixel_pair_t p;
        int r, g, b, yv;
        p = pixel_pair_t'({$urandom, 1'b0});
        if ($urandom_range(0, 2) != 0) begin
            r = int'(tgt_red) + $urandom_range(0, 30) - 15;
            g = int'(tgt_green) + $urandom_range(0, 30) - 15;
            b = int'(tgt_blue) + $urandom_range(0, 30) - 15;
            yv = ((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16;
            p.luma_first  = sat8(yv + $urandom_range(0, 6) - 3);
            p.luma_second = sat8(yv + $urandom_range(0, 6) - 3);
            p.chroma_blue = sat8(((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128);
            p.chroma_red  = sat8(((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128);
        end
        p.frame_end = last;
        return p;
    endfunction

    task automatic send_pair(input pixel_pair_t p);
        int gap;
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        track_pair(p);
        items_sent++;
        gap = tx_steady ? 0 : pick_gap(1'b1);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_frame(input int pairs, input bit close);
        for (int i = 0; i < pairs; i++) send_pair(tinted_pair(close && i == pairs - 1));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (expected_tracks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic [15:0] thr,
                                input logic [15:0] w, input logic [15:0] h,
                                input logic [15:0] mg);
        logic [15:0] vals[7];
        vals = '{16'(r), 16'(g), 16'(b), thr, w, h, mg};
        settle();
        for (int i = 0; i < 7; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_INDEX_BITS'(i);
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (CFG_INDEX_BITS'(i))
                CFG_TARGET_RED:   tgt_red    = vals[i][7:0];
                CFG_TARGET_GREEN: tgt_green  = vals[i][7:0];
                CFG_TARGET_BLUE:  tgt_blue   = vals[i][7:0];
                CFG_THRESHOLD:    thresh     = vals[i];
                CFG_WIDTH:        width_reg  = vals[i][12:0];
                CFG_HEIGHT:       height_reg = vals[i][12:0];
                CFG_MARGIN:       margin_reg = vals[i][11:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_pair('{8'd81, 8'd90, 8'd81, 8'd240, 1'b0});
        send_pair('{8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
        send_pair('{8'd81, 8'd90, 8'd81, 8'd240, 1'b1});
    endtask

    task automatic test_field_extremes();
        write_config(8'd255, 8'd255, 8'd255, 16'd0, 16'd4, 16'd2, 16'd0);
        send_pair('{8'd255, 8'd255, 8'd255, 8'd255, 1'b0});
        send_pair('{8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
        send_pair('{8'd235, 8'd128, 8'd16, 8'd128, 1'b0});
        send_pair('{8'd255, 8'd0, 8'd0, 8'd255, 1'b1});
        write_config(8'd0, 8'd0, 8'd0, 16'd65535, 16'd3, 16'd0, 16'd4095);
        send_frame(3, 1'b1);
        send_pair('{8'd16, 8'd128, 8'd16, 8'd128, 1'b1});
        write_config(8'd128, 8'd129, 8'd127, 16'd30000, 16'd0, 16'd8191, 16'd1);
        send_frame(4, 1'b1);
        write_config(8'd200, 8'd40, 8'd90, 16'd45000, 16'hFFFF, 16'h1FFF, 16'hFFFF);
        send_frame(5, 1'b1);
    endtask

    task automatic test_mid_frame_retarget();
        write_config(8'd20, 8'd200, 8'd60, 16'd40000, 16'd8, 16'd4, 16'd1);
        send_frame(6, 1'b0);
        write_config(8'd240, 8'd10, 8'd250, 16'd40000, 16'd8, 16'd4, 16'd1);
        send_frame(10, 1'b1);
    endtask

    task automatic test_output_backpressure();
        write_config(8'd90, 8'd90, 8'd90, 16'd20000, 16'd2, 16'd1, 16'd0);
        rx_hold_req = 3000;
        tx_steady = 1'b1;
        for (int i = 0; i < 30; i++) send_pair(tinted_pair(1'b1));
        tx_steady = 1'b0;
        settle();
    endtask

    task automatic test_random_frames();
        int count, pairs, rows;
        count = 0;
        while (count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                write_config(8'($urandom), 8'($urandom), 8'($urandom),
                        ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(38000, 65535)),
                        ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 17)),
                        ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 9)),
                        ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 6)));
            end
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            rows = $urandom_range(1, 6);
            pairs = (active_width() > 40) ? $urandom_range(1, 20) : active_width() / 2 * rows;
            if ($urandom_range(0, 9) == 0) pairs = $urandom_range(1, 2 * pairs);
            send_frame(pairs, $urandom_range(0, 9) != 0);
            count += pairs;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
            m_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 9) == 0) rx_stall = pick_gap(1'b0);
        end
    end

    always @(posedge aclk) begin
        track_result_t want;
        if (aresetn && m_valid && m_ready) begin
            tracks_seen++;
            if (expected_tracks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", m_data);
            end else begin
                want = expected_tracks.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch: expected %p actual %p",
                                 tracks_seen, want, m_data);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("color_target_centroid_tracker test failed");
            $finish;
        end
    end

    initial begin
        relatch_span();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_field_extremes();
        test_mid_frame_retarget();
        test_output_backpressure();
        test_random_frames();
        settle();
        if (expected_tracks.size() != 0) mismatches += expected_tracks.size();
        $display("sent %0d pixel pairs, closed %0d frames, checked %0d results, %0d mismatches",
                 items_sent, frames_closed, tracks_seen, mismatches);
        $display("covered register extremes, retargeting mid-frame, output stalls, random frames");
        if (mismatches == 0) begin
            $display("color_target_centroid_tracker test passed");
        end else begin
            $display("color_target_centroid_tracker test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/ctct_pkg.sv
design/ctct_isqrt.sv
design/ctct_divider.sv
design/ctct_lane.sv
design/color_target_centroid_tracker.sv
test/tb_color_target_centroid_tracker.sv
